FILE: hdl/sfr_pkg.sv
package sfr_pkg;

	// Frame layout: a header, 22 channel bytes, a flag byte and a footer.
	localparam int FRAME_BYTES   = 25;
	localparam int STORE_DEPTH   = FRAME_BYTES - 2;
	localparam int CHANNEL_COUNT = 16;
	localparam int CHANNEL_W     = 11;
	localparam int DATA_BYTES    = STORE_DEPTH - 1;
	localparam int DATA_W        = DATA_BYTES * 8;
	localparam int POS_W         = 5;
	localparam int INDEX_W       = 4;
	localparam int OFFSET_W      = 8;

	localparam logic [7:0] HEADER_BYTE = 8'h0F;
	localparam logic [7:0] FOOTER_ZERO = 8'h00;
	localparam logic [3:0] FOOTER_NIB  = 4'h4;
	localparam logic [POS_W-1:0] FINAL_POS = POS_W'(FRAME_BYTES - 1);
	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(CHANNEL_COUNT - 1);

	typedef logic [7:0] byte_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [INDEX_W-1:0] chan_idx_t;
	typedef logic [CHANNEL_W-1:0] chan_val_t;

	// A footer is a zero byte or any byte whose low nibble is four.
	function automatic logic is_footer(input byte_t b);
		return (b == FOOTER_ZERO) || (b[3:0] == FOOTER_NIB);
	endfunction

endpackage

FILE: hdl/sbus_frame_receiver_unit.sv
// When a good footer is taken the snapshot and busy flag are registered; the sixteen
// channel requests then leave the result register one per cycle while output is free.
// Throughput: one byte per cycle; the input stalls only when the final byte of a frame
// arrives while the sixteen requests of the previous frame are still being emitted.
// Reset (arst_n low, asynchronous) returns to waiting for a header, with the previous
// byte taken as a footer and no results pending.
module sbus_frame_receiver_unit
	import sfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [3:0]       channel_index,
	output logic [10:0]      channel_value,
	output logic             digital_ch17,
	output logic             digital_ch18,
	output logic             frame_lost,
	output logic             failsafe_active,
	output logic             last_channel
);

	pos_t              pos_q;
	byte_t             prev_q;
	byte_t             store_q [STORE_DEPTH];
	logic [DATA_W-1:0] snap_q;
	logic [3:0]        flags_q;
	logic              busy_q;
	chan_idx_t         ch_q;
	logic              out_valid_q;
	chan_idx_t         out_index_q;
	chan_val_t         out_value_q;
	logic [3:0]        out_flags_q;
	logic              out_last_q;

	logic              in_accept;
	logic              at_final;
	logic              start_frame;
	logic              frame_good;
	logic              out_load;
	logic [DATA_W-1:0] data_bits;
	logic [OFFSET_W-1:0] bit_offset;

	// The final byte cannot be taken while the last frame's results are still draining.
	assign at_final    = (pos_q >= FINAL_POS);
	assign in_stall    = at_final && busy_q;
	assign in_accept   = in_valid && !in_stall;
	assign start_frame = (pos_q == '0) && (rx_byte == HEADER_BYTE) && is_footer(prev_q);
	assign frame_good  = at_final && is_footer(rx_byte);

	// The stored channel bytes, flattened with the first byte in the lowest bits.
	always_comb begin
		for (int i = 0; i < DATA_BYTES; i++) begin
			data_bits[i*8 +: 8] = store_q[i];
		end
	end

	// Position counter and previous byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= FOOTER_ZERO;
		end else if (in_accept) begin
			prev_q <= rx_byte;
			if (pos_q == '0) begin
				if (start_frame) begin
					pos_q <= pos_t'(1);
				end
			end else if (at_final) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + pos_t'(1);
			end
		end
	end

	// Frame store for the channel bytes and the flag byte; the header is not kept.
	always_ff @(posedge clk) begin
		if (in_accept && (pos_q != '0) && !at_final) begin
			store_q[pos_q - pos_t'(1)] <= rx_byte;
		end
	end

	// Snapshot of a good frame, so that the next frame can be stored meanwhile.
	always_ff @(posedge clk) begin
		if (in_accept && frame_good) begin
			snap_q  <= data_bits;
			flags_q <= store_q[STORE_DEPTH-1][3:0];
		end
	end

	assign out_load   = !out_valid_q || !out_stall;
	assign bit_offset = OFFSET_W'(ch_q) * OFFSET_W'(CHANNEL_W);

	// Emission counter over the sixteen channels of the snapshot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= busy_q;
				if (busy_q) begin
					ch_q <= ch_q + chan_idx_t'(1);
					if (ch_q == LAST_INDEX) begin
						busy_q <= 1'b0;
					end
				end
			end
			if (in_accept && frame_good) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (out_load && busy_q) begin
			out_index_q <= ch_q;
			out_value_q <= snap_q[bit_offset +: CHANNEL_W];
			out_flags_q <= flags_q;
			out_last_q  <= (ch_q == LAST_INDEX);
		end
	end

	assign out_valid       = out_valid_q;
	assign channel_index   = out_index_q;
	assign channel_value   = out_value_q;
	assign digital_ch17    = out_flags_q[0];
	assign digital_ch18    = out_flags_q[1];
	assign frame_lost      = out_flags_q[2];
	assign failsafe_active = out_flags_q[3];
	assign last_channel    = out_last_q;

endmodule

FILE: hdl/sfr_checker.sv
module sfr_checker
	import sfr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  channel_index,
	input logic        digital_ch17,
	input logic        digital_ch18,
	input logic        frame_lost,
	input logic        failsafe_active,
	input logic        last_channel
);

	// A stalled request keeps its channel.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel_index))
		else $error("stalled result changed");

	// The last-channel mark sits on channel fifteen alone.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_channel == (channel_index == LAST_INDEX)))
		else $error("last channel mark on wrong channel");

	// Within a frame the channels follow one another without a gap.
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_channel |=>
		out_valid && (channel_index == $past(channel_index) + 4'd1))
		else $error("channel sequence broken");

	// The flags of one frame do not change between its channels.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_channel |=>
		$stable(digital_ch17) && $stable(digital_ch18) &&
		$stable(frame_lost) && $stable(failsafe_active))
		else $error("flags changed within a frame");

endmodule

bind sbus_frame_receiver_unit sfr_checker u_sfr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.channel_index   (channel_index),
	.digital_ch17    (digital_ch17),
	.digital_ch18    (digital_ch18),
	.frame_lost      (frame_lost),
	.failsafe_active (failsafe_active),
	.last_channel    (last_channel)
);

FILE: sim/sbus_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps

module sbus_frame_receiver_unit_tb;
	import sfr_pkg::*;

	// Bytes held for one frame: header, channel bytes and flag byte.
	localparam int FRAME_STORE    = FRAME_BYTES - 1;
	localparam int FLAG_POS       = FRAME_BYTES - 2;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 12;
	localparam int MAX_PRINTED    = 100;

	typedef struct packed {
		chan_idx_t idx;
		chan_val_t value;
		logic      ch17;
		logic      ch18;
		logic      lost;
		logic      failsafe;
		logic      last;
	} chan_result_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	byte_t     rx_byte = 8'h00;
	logic      out_valid;
	logic      out_stall = 1'b0;
	chan_idx_t channel_index;
	chan_val_t channel_value;
	logic      digital_ch17;
	logic      digital_ch18;
	logic      frame_lost;
	logic      failsafe_active;
	logic      last_channel;

	// Predictor state for the frame decoder.
	pos_t         rx_pos = '0;
	byte_t        last_rx = 8'h00;
	byte_t        frame_bytes [FRAME_STORE];
	chan_result_t expected_channels [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	sbus_frame_receiver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.digital_ch17(digital_ch17),
		.digital_ch18(digital_ch18),
		.frame_lost(frame_lost),
		.failsafe_active(failsafe_active),
		.last_channel(last_channel)
	);

	// Clock with a period of 4 ns.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A footer is a zero byte, or any byte whose low nibble is four.
	function automatic logic footer_ok(input byte_t b);
		return (b == 8'h00) || (b[3:0] == 4'h4);
	endfunction

	// Advances the decoder state by one byte and queues the sixteen channels
	// of a frame that closes with a good footer.
	function automatic void predict_byte(input byte_t b);
		logic [DATA_W-1:0] packed_data;
		byte_t             flags;
		chan_result_t      res;
		if (rx_pos == 0) begin
			if (b == HEADER_BYTE && footer_ok(last_rx)) begin
				frame_bytes[0] = b;
				rx_pos = pos_t'(1);
			end
		end else if (rx_pos < FRAME_STORE) begin
			frame_bytes[rx_pos] = b;
			rx_pos = rx_pos + 1'b1;
		end else begin
			rx_pos = '0;
			if (footer_ok(b)) begin
				for (int k = 0; k < DATA_W / 8; k++)
					packed_data[8*k +: 8] = frame_bytes[k+1];
				flags = frame_bytes[FLAG_POS];
				for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
					res.idx      = chan_idx_t'(ch);
					res.value    = packed_data[CHANNEL_W*ch +: CHANNEL_W];
					res.ch17     = flags[0];
					res.ch18     = flags[1];
					res.lost     = flags[2];
					res.failsafe = flags[3];
					res.last     = (ch == CHANNEL_COUNT - 1);
					expected_channels.push_back(res);
				end
			end
		end
		last_rx = b;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < MAX_PRINTED)
			$display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input int got, input int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	// Sends one byte request, with random idle cycles ahead of it, and feeds
	// the predictor once it has been taken.
	task automatic send_byte(input byte_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_byte(b);
	endtask

	// Sends a whole frame: header, packed channels, flags and footer.
	task automatic send_frame(input logic [DATA_W-1:0] chans, input byte_t flags,
			input byte_t footer);
		send_byte(HEADER_BYTE);
		for (int k = 0; k < DATA_W / 8; k++)
			send_byte(chans[8*k +: 8]);
		send_byte(flags);
		send_byte(footer);
	endtask

	// Brings the decoder back to waiting, with a footer as the last byte.
	task automatic sync_idle();
		while (rx_pos != 0)
			send_byte(byte_t'($urandom_range(255)));
		if (!footer_ok(last_rx))
			send_byte(8'h00);
	endtask

	// Stops sending and waits until every expected channel has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_channels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] random_channels();
		logic [DATA_W-1:0] chans;
		for (int k = 0; k < DATA_W / 8; k++)
			chans[8*k +: 8] = byte_t'($urandom_range(255));
		return chans;
	endfunction

	function automatic byte_t random_footer();
		if ($urandom_range(3) == 0)
			return 8'h00;
		return {4'($urandom_range(15)), 4'h4};
	endfunction

	function automatic byte_t random_bad_footer();
		byte_t b;
		do
			b = byte_t'($urandom_range(255));
		while (footer_ok(b));
		return b;
	endfunction

	// A header straight after reset, extremes of the channel values, every flag,
	// each kind of footer, a bad footer, a header after a byte that is not a
	// footer, and header bytes carried as data.
	task automatic test_directed();
		logic [DATA_W-1:0] ramp;
		send_idle_pct = 0;
		stall_pct = 0;
		sync_idle();
		send_frame('1, 8'h0F, 8'h04);
		send_frame(random_channels(), 8'h0F, 8'h05);
		send_byte(HEADER_BYTE);
		send_byte(8'h24);
		send_frame({(DATA_W / 8){HEADER_BYTE}}, 8'h0A, 8'h84);
		for (int ch = 0; ch < CHANNEL_COUNT; ch++)
			ramp[CHANNEL_W*ch +: CHANNEL_W] = (ch % 2) ? chan_val_t'(2047 - ch) :
				chan_val_t'(ch);
		send_frame(ramp, 8'h03, 8'h00);
		drain();
	endtask

	// Mostly good frames with random contents; some with bad footers, some cut
	// short, and some plain line noise with stray headers.
	task automatic test_random(input int send_pct, input int recv_pct, input int quota);
		int sent;
		int pick;
		int cut;
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(99);
			sync_idle();
			if (pick < 70) begin
				send_frame(random_channels(), byte_t'($urandom_range(255)), random_footer());
				sent += FRAME_BYTES;
			end else if (pick < 80) begin
				send_frame(random_channels(), byte_t'($urandom_range(255)),
					random_bad_footer());
				sent += FRAME_BYTES;
			end else if (pick < 90) begin
				cut = $urandom_range(1, FRAME_BYTES - 2);
				send_byte(HEADER_BYTE);
				for (int k = 0; k < cut; k++)
					send_byte(byte_t'($urandom_range(255)));
				sent += cut + 1;
			end else begin
				cut = $urandom_range(1, 8);
				for (int k = 0; k < cut; k++)
					send_byte(($urandom_range(3) == 0) ? HEADER_BYTE :
						byte_t'($urandom_range(255)));
				sent += cut;
			end
		end
		drain();
	endtask

	// Holds the output off for a long stretch while frames keep arriving, so
	// that the final byte of a later frame is stalled at the input.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		sync_idle();
		hold_left = HOLD_CYCLES;
		for (int f = 0; f < 2; f++)
			send_frame(random_channels(), byte_t'($urandom_range(255)), random_footer());
		drain();
	endtask

	// Receiver: random stalls, or a solid hold-off while one is requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compares each channel request taken with the oldest expectation.
	always @(posedge clk) begin
		chan_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_channels.size() == 0) begin
				report_mismatch("channel request with none expected", channel_index, -1);
			end else begin
				want = expected_channels.pop_front();
				check_field("channel_index", channel_index, want.idx);
				check_field("channel_value", channel_value, want.value);
				check_field("digital_ch17", digital_ch17, want.ch17);
				check_field("digital_ch18", digital_ch18, want.ch18);
				check_field("frame_lost", frame_lost, want.lost);
				check_field("failsafe_active", failsafe_active, want.failsafe);
				check_field("last_channel", last_channel, want.last);
			end
		end
	end

	// Watchdog on cycles in which neither side moves a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no progress", $realtime);
				$display("** sbus_frame_receiver_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 0, 10);
		test_random(55, 0, 10);
		test_random(0, 55, 10);
		test_random(33, 33, 10);
		test_output_backpressure();
		if (mismatches == 0 && expected_channels.size() == 0) begin
			$display("** sbus_frame_receiver_unit: PASSED **");
		end else begin
			$display("** sbus_frame_receiver_unit: FAILED **");
		end
		$finish;
	end

endmodule
